FILE: hw/rtl/asd_pkg.sv
package asd_pkg;

  // sample, threshold, step, margin, count and configuration widths
  localparam int unsigned SampleW  = 13;
  localparam int unsigned XThrW    = 13;
  localparam int unsigned YzThrW   = 10;
  localparam int unsigned AdjW     = 2;
  localparam int unsigned MarginW  = 13;
  localparam int unsigned CountW   = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  // packed stream widths
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 56;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_X_THRESHOLD    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_YZ_THRESH_MIN  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_YZ_THRESH_MAX  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ADJUST_STEP    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RAISE_MARGIN   = 3'd4;

  // reset values
  localparam logic [XThrW-1:0]   X_THRESHOLD_RST   = 13'd35;
  localparam logic [YzThrW-1:0]  YZ_THRESH_MIN_RST = 10'd175;
  localparam logic [YzThrW-1:0]  YZ_THRESH_MAX_RST = 10'd195;
  localparam logic [AdjW-1:0]    ADJUST_STEP_RST   = 2'd2;
  localparam logic [MarginW-1:0] RAISE_MARGIN_RST  = 13'd200;
  localparam logic [YzThrW-1:0]  YZ_THRESH_RST     = 10'd185;
  localparam logic [YzThrW-1:0]  YZ_THRESH_SAT     = 10'd1023;

  typedef struct packed {
    logic [XThrW-1:0]   x_threshold;
    logic [YzThrW-1:0]  yz_threshold_min;
    logic [YzThrW-1:0]  yz_threshold_max;
    logic [AdjW-1:0]    adjust_step;
    logic [MarginW-1:0] raise_margin;
  } cfg_t;

  // magnitude of a signed sample, full range fits unsigned
  function automatic logic [SampleW-1:0] mag(input logic signed [SampleW-1:0] v);
    logic [SampleW-1:0] r;
    r = v[SampleW-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

  // | |cur| - |prev| |
  function automatic logic [SampleW-1:0] mag_diff(input logic signed [SampleW-1:0] cur,
                                                  input logic signed [SampleW-1:0] prev);
    logic [SampleW:0] d;
    d = {1'b0, mag(cur)} - {1'b0, mag(prev)};
    if (d[SampleW]) begin
      d = ~d + 1'b1;
    end
    return d[SampleW-1:0];
  endfunction

endpackage

FILE: hw/rtl/asd_cfg_regs.sv
module asd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [asd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [asd_pkg::CfgDataW-1:0]  cfg_wdata,
  output asd_pkg::cfg_t                 cfg
);
  import asd_pkg::*;

  // register file, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_threshold      <= X_THRESHOLD_RST;
      cfg.yz_threshold_min <= YZ_THRESH_MIN_RST;
      cfg.yz_threshold_max <= YZ_THRESH_MAX_RST;
      cfg.adjust_step      <= ADJUST_STEP_RST;
      cfg.raise_margin     <= RAISE_MARGIN_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_X_THRESHOLD:   cfg.x_threshold      <= cfg_wdata[XThrW-1:0];
        REG_YZ_THRESH_MIN: cfg.yz_threshold_min <= cfg_wdata[YzThrW-1:0];
        REG_YZ_THRESH_MAX: cfg.yz_threshold_max <= cfg_wdata[YzThrW-1:0];
        REG_ADJUST_STEP:   cfg.adjust_step      <= cfg_wdata[AdjW-1:0];
        REG_RAISE_MARGIN:  cfg.raise_margin     <= cfg_wdata[MarginW-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/asd_adapt.sv
module asd_adapt (
  input  logic [asd_pkg::SampleW-1:0] diff,
  input  logic [asd_pkg::YzThrW-1:0]  thr,
  input  asd_pkg::cfg_t               cfg,
  output logic                        hit,
  output logic [asd_pkg::YzThrW-1:0]  thr_next
);
  import asd_pkg::*;

  logic [SampleW-1:0] overshoot;
  logic               raise;
  logic [YzThrW-1:0]  clamped;
  logic [YzThrW:0]    raised;

  // reach test and overshoot beyond the threshold
  always_comb begin
    hit       = diff >= {{(SampleW-YzThrW){1'b0}}, thr};
    overshoot = diff - {{(SampleW-YzThrW){1'b0}}, thr};
    raise     = hit && (overshoot > cfg.raise_margin);
  end

  // when raising: clamp (upper bound wins), then raise with saturation; else pass thr on
  always_comb begin
    if (thr > cfg.yz_threshold_max) begin
      clamped = cfg.yz_threshold_max;
    end else if (thr < cfg.yz_threshold_min) begin
      clamped = cfg.yz_threshold_min;
    end else begin
      clamped = thr;
    end
    raised = {1'b0, clamped} + {{(YzThrW+1-AdjW){1'b0}}, cfg.adjust_step};
    if (!raise) begin
      thr_next = thr;
    end else if (clamped < cfg.yz_threshold_max) begin
      thr_next = raised[YzThrW] ? YZ_THRESH_SAT : raised[YzThrW-1:0];
    end else begin
      thr_next = clamped;
    end
  end

endmodule

FILE: hw/rtl/accel_step_detector.sv
// a result passes through the sample register and then the result register
// throughput: one sample per cycle, sustained while the result side keeps up
// the sample register and the result register each hold one item; a stalled
// result side stops the input after those two are full
// reset (rst, synchronous): thresholds 185, count 0, no previous sample, all
// configuration registers back to their defaults, both stages empty
module accel_step_detector (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // accel_x[12:0], accel_y[25:13], accel_z[38:26], zero pad [39]
  input  logic [asd_pkg::InDataW-1:0]    s_tdata,
  // vibrating[0]
  input  logic [0:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // step_detected[0], step_total[32:1], y_threshold_now[42:33],
  // z_threshold_now[52:43], zero pad [55:53]
  output logic [asd_pkg::OutDataW-1:0]   m_tdata,
  input  logic                           cfg_wen,
  input  logic [asd_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [asd_pkg::CfgDataW-1:0]   cfg_wdata
);
  import asd_pkg::*;

  cfg_t cfg;

  logic                      in_valid;
  logic signed [SampleW-1:0] in_x;
  logic signed [SampleW-1:0] in_y;
  logic signed [SampleW-1:0] in_z;
  logic                      in_vib;

  logic signed [SampleW-1:0] prev_x;
  logic signed [SampleW-1:0] prev_y;
  logic signed [SampleW-1:0] prev_z;
  logic [YzThrW-1:0]         y_threshold;
  logic [YzThrW-1:0]         z_threshold;
  logic                      primed;
  logic [CountW-1:0]         step_counter;

  logic                      out_valid;
  logic [OutDataW-1:0]       out_data;

  logic                      advance;
  logic [SampleW-1:0]        dx;
  logic [SampleW-1:0]        dy;
  logic [SampleW-1:0]        dz;
  logic                      hit_x;
  logic                      hit_y;
  logic                      hit_z;
  logic [YzThrW-1:0]         y_adapt;
  logic [YzThrW-1:0]         z_adapt;
  logic                      step;
  logic [YzThrW-1:0]         y_threshold_next;
  logic [YzThrW-1:0]         z_threshold_next;
  logic [CountW-1:0]         step_counter_next;

  asd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // pipeline flow control
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // sample register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_x   <= s_tdata[SampleW-1:0];
      in_y   <= s_tdata[2*SampleW-1:SampleW];
      in_z   <= s_tdata[3*SampleW-1:2*SampleW];
      in_vib <= s_tuser[0];
    end
  end

  // magnitude differences against the previous sample
  always_comb begin
    dx    = mag_diff(in_x, prev_x);
    dy    = mag_diff(in_y, prev_y);
    dz    = mag_diff(in_z, prev_z);
    hit_x = dx >= cfg.x_threshold;
  end

  asd_adapt u_adapt_y (
    .diff     (dy),
    .thr      (y_threshold),
    .cfg      (cfg),
    .hit      (hit_y),
    .thr_next (y_adapt)
  );

  asd_adapt u_adapt_z (
    .diff     (dz),
    .thr      (z_threshold),
    .cfg      (cfg),
    .hit      (hit_z),
    .thr_next (z_adapt)
  );

  // step decision and state update, first sample only primes
  always_comb begin
    step              = primed && hit_x && (hit_y || hit_z) && !in_vib;
    y_threshold_next  = primed ? y_adapt : y_threshold;
    z_threshold_next  = primed ? z_adapt : z_threshold;
    step_counter_next = step_counter + {{(CountW-1){1'b0}}, step};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x       <= '0;
      prev_y       <= '0;
      prev_z       <= '0;
      y_threshold  <= YZ_THRESH_RST;
      z_threshold  <= YZ_THRESH_RST;
      primed       <= 1'b0;
      step_counter <= '0;
    end else if (in_valid && advance) begin
      prev_x       <= in_x;
      prev_y       <= in_y;
      prev_z       <= in_z;
      y_threshold  <= y_threshold_next;
      z_threshold  <= z_threshold_next;
      primed       <= 1'b1;
      step_counter <= step_counter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      out_data <= {3'b000, z_threshold_next, y_threshold_next, step_counter_next, step};
    end
  end

endmodule

FILE: hw/rtl/asd_checker.sv
module asd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [asd_pkg::OutDataW-1:0]  m_tdata
);
  import asd_pkg::*;

  logic [CountW-1:0] last_total;

  // step count seen on the last result request
  always_ff @(posedge clk) begin
    if (rst) begin
      last_total <= '0;
    end else if (m_tvalid && m_tready) begin
      last_total <= m_tdata[CountW:1];
    end
  end

  // count moves by exactly the step flag between results
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |->
      (m_tdata[CountW:1] == last_total + {{(CountW-1){1'b0}}, m_tdata[0]}))
    else $error("step count does not follow step flag");

  // a result only appears after a sample request has passed the sample register
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a sample request");

  // a draining result side never blocks the input
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while results drain");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind accel_step_detector asd_checker u_asd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
